// ----- rtl/core/frx_pkg.sv -----
package frx_pkg;

  // Frame parser phases.
  typedef enum logic [2:0] {
    PH_WAIT = 3'd0,
    PH_TYPE = 3'd1,
    PH_LEN  = 3'd2,
    PH_DATA = 3'd3,
    PH_CRCH = 3'd4,
    PH_CRCL = 3'd5
  } phase_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_BUSY    = 3'd0,
    ST_GOOD    = 3'd1,
    ST_CRC_ERR = 3'd2,
    ST_LEN_REJ = 3'd3,
    ST_READ    = 3'd4
  } status_e;

  // Request kinds.
  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_READ = 1'b1
  } kind_e;

  // Configuration register indexes.
  localparam logic [1:0] CfgStartByte    = 2'd0;
  localparam logic [1:0] CfgPayloadLimit = 2'd1;

  localparam logic [7:0]  StartByteReset    = 8'd2;
  localparam logic [7:0]  PayloadLimitReset = 8'd255;
  localparam logic [15:0] CrcInit           = 16'hFFFF;
  localparam logic [15:0] CrcPoly           = 16'h1021;
  localparam logic [15:0] CrcTopBit         = 16'h8000;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } in_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] frame_type;
    logic [7:0] frame_length;
    logic       payload_kept;
    logic [7:0] read_data;
  } out_t;

  // Payload store write request from the parser.
  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } wr_req_t;

  // CRC-16/CCITT-FALSE update for one byte, MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CrcTopBit) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/frx_parser.sv -----
module frx_parser #(
  parameter int MAX_PAYLOAD = 255
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  byte_acc_i,
  input  logic [7:0]            byte_i,
  input  logic [7:0]            start_byte_i,
  input  logic [7:0]            payload_limit_i,
  output frx_pkg::out_t         res_o,
  output frx_pkg::wr_req_t      wr_o
);

  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

  frx_pkg::phase_e phase_q, phase_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crch_q, crch_d;
  logic [15:0] crc_next;
  logic [7:0]  cnt_inc;

  assign crc_next = frx_pkg::crc16_byte(crc_q, byte_i);
  assign cnt_inc  = cnt_q + 8'd1;

  // Next state.
  always_comb begin
    phase_d = phase_q;
    type_d  = type_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    crc_d   = crc_q;
    crch_d  = crch_q;
    if (byte_acc_i) begin
      unique case (phase_q)
        frx_pkg::PH_TYPE: begin
          type_d  = byte_i;
          crc_d   = crc_next;
          phase_d = frx_pkg::PH_LEN;
        end
        frx_pkg::PH_LEN: begin
          len_d = byte_i;
          crc_d = crc_next;
          if (byte_i == 8'd0) begin
            phase_d = frx_pkg::PH_CRCH;
          end else if (byte_i > MaxLen) begin
            phase_d = frx_pkg::PH_WAIT;
          end else begin
            cnt_d   = 8'd0;
            phase_d = frx_pkg::PH_DATA;
          end
        end
        frx_pkg::PH_DATA: begin
          crc_d = crc_next;
          cnt_d = cnt_inc;
          if (cnt_inc >= len_q) begin
            phase_d = frx_pkg::PH_CRCH;
          end
        end
        frx_pkg::PH_CRCH: begin
          crch_d  = byte_i;
          phase_d = frx_pkg::PH_CRCL;
        end
        frx_pkg::PH_CRCL: begin
          phase_d = frx_pkg::PH_WAIT;
        end
        default: begin
          crc_d   = frx_pkg::CrcInit;
          phase_d = (byte_i == start_byte_i) ? frx_pkg::PH_TYPE : frx_pkg::PH_WAIT;
        end
      endcase
    end
  end

  // Outputs.
  always_comb begin
    res_o = '{status: frx_pkg::ST_BUSY, frame_type: 8'd0, frame_length: 8'd0,
              payload_kept: 1'b0, read_data: 8'd0};
    wr_o  = '{en: 1'b0, addr: cnt_q, data: byte_i};
    if (byte_acc_i) begin
      unique case (phase_q)
        frx_pkg::PH_LEN: begin
          if (byte_i > MaxLen) begin
            res_o.status = frx_pkg::ST_LEN_REJ;
          end
        end
        frx_pkg::PH_DATA: begin
          wr_o.en = (cnt_q < MaxLen);
        end
        frx_pkg::PH_CRCL: begin
          if ({crch_q, byte_i} == crc_q) begin
            res_o.status       = frx_pkg::ST_GOOD;
            res_o.frame_type   = type_q;
            res_o.frame_length = len_q;
            res_o.payload_kept = (len_q != 8'd0) && (len_q <= payload_limit_i);
          end else begin
            res_o.status = frx_pkg::ST_CRC_ERR;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= frx_pkg::PH_WAIT;
      type_q  <= 8'd0;
      len_q   <= 8'd0;
      cnt_q   <= 8'd0;
      crc_q   <= frx_pkg::CrcInit;
      crch_q  <= 8'd0;
    end else begin
      phase_q <= phase_d;
      type_q  <= type_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      crch_q  <= crch_d;
    end
  end

`ifndef SYNTHESIS
  // The store is written only while payload bytes arrive.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.en |-> (byte_acc_i && phase_q == frx_pkg::PH_DATA))
    else $error("payload write outside the data phase");

  // A length byte that is rejected sends the parser back to waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_acc_i && res_o.status == frx_pkg::ST_LEN_REJ) |=> phase_q == frx_pkg::PH_WAIT)
    else $error("rejected length did not end the frame");

  // The data phase never runs past the frame length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == frx_pkg::PH_DATA) |-> (cnt_q < len_q))
    else $error("payload count ran past the frame length");
`endif

endmodule

// ----- rtl/core/framed_packet_receiver_crc16.sv -----
// Pipeline: an accepted request is registered in stage one, then in the output register.
// Throughput: one request per cycle unless the input is stalled; the CRC of a byte is
// done in the accepting cycle and the payload store serves one write or one registered
// read per cycle. Reset: rst_ni is asynchronous and active low; it returns the parser to
// waiting for a start byte, restores the configuration defaults and empties the pipeline.
// The payload store is not cleared and holds unknown data until payload bytes are written.
module framed_packet_receiver_crc16 #(
  parameter int MAX_PAYLOAD = 255
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  frx_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output frx_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [7:0]    cfg_data_i
);

  localparam int         AddrW  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

  // Configuration registers. Writes are always taken.
  logic [7:0] start_byte_q;
  logic [7:0] payload_limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q    <= frx_pkg::StartByteReset;
      payload_limit_q <= frx_pkg::PayloadLimitReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        frx_pkg::CfgStartByte:    start_byte_q    <= cfg_data_i;
        frx_pkg::CfgPayloadLimit: payload_limit_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Pipeline control. Stage one holds the parser result and the memory read,
  // the output register holds the finished result. Stage one advances when it
  // is empty or when the output register can take its contents, so a new
  // request is accepted while a finished result still waits downstream.
  logic p1_valid_q;
  logic out_valid_q;
  logic out_free;
  logic p1_en;
  logic accept;
  logic byte_acc;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign p1_en      = !p1_valid_q || out_free;
  assign in_stall_o = !p1_en;
  assign accept     = in_valid_i && p1_en;
  assign byte_acc   = accept && (in_data_i.kind == frx_pkg::KIND_BYTE);

  // Frame parser: phase, CRC and counters; one received byte per cycle unless stalled.
  frx_pkg::out_t    parse_res;
  frx_pkg::wr_req_t wr_req;

  frx_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .byte_acc_i     (byte_acc),
    .byte_i         (in_data_i.rx_byte),
    .start_byte_i   (start_byte_q),
    .payload_limit_i(payload_limit_q),
    .res_o          (parse_res),
    .wr_o           (wr_req)
  );

  // Payload store: one write port from the parser, one registered read port.
  // A read is always accepted in a later cycle than the write of the same entry,
  // so the registered read sees the written byte without forwarding.
  logic [7:0]       mem [MAX_PAYLOAD];
  logic [7:0]       rd_q;
  logic [AddrW-1:0] raddr;
  logic             rd_in_range;

  assign raddr       = in_data_i.read_index[AddrW-1:0];
  assign rd_in_range = (in_data_i.read_index < MaxLen);

  always_ff @(posedge clk_i) begin
    if (wr_req.en) begin
      mem[wr_req.addr[AddrW-1:0]] <= wr_req.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_en) begin
      rd_q <= mem[raddr];
    end
  end

  // Stage one payload.
  frx_pkg::out_t p1_res_q;
  logic          p1_rd_ok_q;
  frx_pkg::out_t p1_res_d;

  always_comb begin
    p1_res_d = parse_res;
    if (in_data_i.kind == frx_pkg::KIND_READ) begin
      p1_res_d = '{status: frx_pkg::ST_READ, frame_type: 8'd0, frame_length: 8'd0,
                   payload_kept: 1'b0, read_data: 8'd0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_en) begin
      p1_res_q   <= p1_res_d;
      p1_rd_ok_q <= (in_data_i.kind == frx_pkg::KIND_READ) && rd_in_range;
    end
  end

  // Output register payload. The read byte joins the result here, and an
  // out-of-range read answers zero.
  frx_pkg::out_t out_q;
  frx_pkg::out_t out_d;

  always_comb begin
    out_d           = p1_res_q;
    out_d.read_data = p1_rd_ok_q ? rd_q : 8'd0;
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (p1_en) begin
        p1_valid_q <= accept;
      end
      if (out_free) begin
        out_valid_q <= p1_valid_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // The input side stalls only when stage one is full and cannot drain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (p1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled with room in the pipeline");

  // A full stage one that cannot drain keeps its request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p1_valid_q && !out_free) |=> p1_valid_q)
    else $error("stage one lost a request while blocked");

  // Frame fields are nonzero only on a good frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != frx_pkg::ST_GOOD) |->
      (out_q.frame_type == 8'd0 && out_q.frame_length == 8'd0 && !out_q.payload_kept))
    else $error("frame fields set on a result that is not a good frame");

  // Read data appears only on a read reply.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != frx_pkg::ST_READ) |-> (out_q.read_data == 8'd0))
    else $error("read data set on a result that is not a read reply");
`endif

endmodule

// ----- dv/framed_packet_receiver_crc16_tb.sv -----
module framed_packet_receiver_crc16_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import frx_pkg::*;

  // The payload store depth of the instance under test.
  localparam int StoreDepth = 255;
  // The run ends as a failure once the count of cycles without a handshake reaches this.
  localparam int IdleLimit = 1000;
  // Cycles to wait after the last result before a register write or the end of the run.
  localparam int SettleCycles = 4;

  // One CRC-16/CCITT-FALSE step, written as a bit-serial shift register that takes the
  // byte most significant bit first.
  function automatic logic [15:0] crc_after(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic feedback;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      feedback = c[15] ^ b[i];
      c = {c[14:0], 1'b0};
      if (feedback) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  // Mirrors the parser and the payload store, and keeps the expected results in order.
  class frame_scoreboard;
    logic [7:0]  start_byte    = StartByteReset;
    logic [7:0]  payload_limit = PayloadLimitReset;
    phase_e      phase         = PH_WAIT;
    logic [7:0]  held_type     = '0;
    logic [7:0]  held_length   = '0;
    logic [7:0]  byte_count    = '0;
    logic [15:0] running_crc   = CrcInit;
    logic [7:0]  crc_high      = '0;
    logic [7:0]  store[StoreDepth];
    // Entries below this index have been written; writes always start at zero.
    int unsigned filled        = 0;
    out_t        expected_q[$];
    int unsigned mismatches    = 0;
    int unsigned good_frames   = 0;
    int unsigned kept_frames   = 0;
    int unsigned crc_errors    = 0;
    int unsigned read_replies  = 0;

    function void write_register(input logic [1:0] idx, input logic [7:0] value);
      if (idx == CfgStartByte) begin
        start_byte = value;
      end else if (idx == CfgPayloadLimit) begin
        payload_limit = value;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Advances the parser for one accepted request and queues the result it causes.
    function void note_request(input in_t req);
      out_t want;
      logic [7:0] c;
      want = '0;
      want.status = ST_BUSY;
      c = req.rx_byte;
      if (req.kind == KIND_READ) begin
        want.status = ST_READ;
        if (int'(req.read_index) < StoreDepth) begin
          want.read_data = store[req.read_index];
        end
      end else begin
        case (phase)
          PH_TYPE: begin
            held_type = c;
            running_crc = crc_after(running_crc, c);
            phase = PH_LEN;
          end
          PH_LEN: begin
            held_length = c;
            running_crc = crc_after(running_crc, c);
            if (c == 8'd0) begin
              phase = PH_CRCH;
            end else if (int'(c) > StoreDepth) begin
              want.status = ST_LEN_REJ;
              phase = PH_WAIT;
            end else begin
              byte_count = '0;
              phase = PH_DATA;
            end
          end
          PH_DATA: begin
            if (int'(byte_count) < StoreDepth) begin
              store[byte_count] = c;
              if (byte_count >= filled) begin
                filled = byte_count + 1;
              end
            end
            running_crc = crc_after(running_crc, c);
            byte_count = byte_count + 8'd1;
            if (byte_count >= held_length) begin
              phase = PH_CRCH;
            end
          end
          PH_CRCH: begin
            crc_high = c;
            phase = PH_CRCL;
          end
          PH_CRCL: begin
            phase = PH_WAIT;
            if ({crc_high, c} == running_crc) begin
              want.status = ST_GOOD;
              want.frame_type = held_type;
              want.frame_length = held_length;
              want.payload_kept = (held_length != 8'd0) && (held_length <= payload_limit);
            end else begin
              want.status = ST_CRC_ERR;
            end
          end
          default: begin
            phase = PH_WAIT;
            running_crc = CrcInit;
            if (c == start_byte) begin
              phase = PH_TYPE;
            end
          end
        endcase
      end
      expected_q.push_back(want);
    endfunction

    // Compares one accepted result against the oldest expectation.
    function void check_result(input out_t got);
      out_t want;
      bit bad;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: status %0d type %0h len %0d kept %0b data %0h",
                   got.status, got.frame_type, got.frame_length, got.payload_kept,
                   got.read_data);
        end
        return;
      end
      want = expected_q.pop_front();
      bad = (got.status !== want.status) || (got.frame_type !== want.frame_type) ||
            (got.frame_length !== want.frame_length) ||
            (got.payload_kept !== want.payload_kept) || (got.read_data !== want.read_data);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at %0t: expected status %0d type %0h len %0d kept %0b data %0h",
                   $realtime, want.status, want.frame_type, want.frame_length,
                   want.payload_kept, want.read_data);
          $display("                  actual status %0d type %0h len %0d kept %0b data %0h",
                   got.status, got.frame_type, got.frame_length, got.payload_kept,
                   got.read_data);
        end
      end
      if (want.status == ST_GOOD) begin
        good_frames++;
        if (want.payload_kept) begin
          kept_frames++;
        end
      end else if (want.status == ST_CRC_ERR) begin
        crc_errors++;
      end else if (want.status == ST_READ) begin
        read_replies++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [7:0] cfg_data_i;

  framed_packet_receiver_crc16 #(
    .MAX_PAYLOAD(StoreDepth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  frame_scoreboard sb = new();

  // When calm is set neither side idles, so requests and results flow back to back.
  bit calm = 1'b0;
  // When set, a read request is now and then slipped in ahead of a serial byte,
  // which also lands reads in the middle of frames.
  bit mix_reads = 1'b0;
  int unsigned requests_sent = 0;
  int unsigned ignored_sent = 0;
  int unsigned settings_used = 1;
  int stall_left = 0;
  int idle_cycles = 0;
  // Payload of the next frame to send.
  logic [7:0] payload_q[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Both sides draw a random wait per item; about two thirds of the draws
  // are zero so that long runs without any idling occur as well.
  function automatic int draw_gap();
    if (calm || $urandom_range(0, 2) != 0) begin
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  // Only entries that a payload byte has reached are read back, plus now and then the
  // index just past the store, which must answer zero.
  function automatic int pick_read_index();
    if (sb.filled == 0 || $urandom_range(0, 19) == 0) begin
      return StoreDepth;
    end
    return $urandom_range(0, sb.filled - 1);
  endfunction

  // Result side: every accepted result is checked, then the stall is held high for a
  // freshly drawn number of cycles. The stall runs on even while no result is waiting,
  // so it lands on every phase of the pipeline.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(out_data_o);
        stall_left = draw_gap();
        if (stall_left > 0) begin
          out_stall_i <= 1'b1;
        end
      end else if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) begin
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
                 (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("timeout: no handshake for %0d cycles", IdleLimit);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Presents one request and returns at the edge that accepts it. Valid stays high on
  // return, so a following request with no gap goes out back to back.
  task automatic send_request(input in_t req);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(req);
    requests_sent++;
  endtask

  task automatic send_read(input int idx);
    in_t req;
    req.kind = KIND_READ;
    req.rx_byte = 8'($urandom);
    req.read_index = 8'(idx);
    send_request(req);
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_t req;
    if (mix_reads && $urandom_range(0, 9) == 0) begin
      send_read(pick_read_index());
    end
    req.kind = KIND_BYTE;
    req.rx_byte = b;
    req.read_index = 8'($urandom);
    send_request(req);
  endtask

  // Sends the start byte and then type, length, payload_q and the CRC. A corrupt frame
  // has one CRC bit flipped. A nonnegative cut stops after that many bytes following
  // the start byte, which leaves the parser inside the frame.
  task automatic send_packet(input logic [7:0] ftype, input bit corrupt, input int cut);
    logic [7:0] body[$];
    logic [15:0] crc;
    body.push_back(ftype);
    body.push_back(8'(payload_q.size()));
    foreach (payload_q[i]) body.push_back(payload_q[i]);
    crc = CrcInit;
    foreach (body[i]) crc = crc_after(crc, body[i]);
    if (corrupt) begin
      crc = crc ^ (16'd1 << $urandom_range(0, 15));
    end
    body.push_back(crc[15:8]);
    body.push_back(crc[7:0]);
    send_byte(sb.start_byte);
    foreach (body[i]) begin
      if (cut < 0 || i < cut) begin
        send_byte(body[i]);
      end
    end
  endtask

  // Pauses the sender until every result has come back, then lets the pipeline settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [1:0] idx, input logic [7:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_register(idx, value);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure(input logic [7:0] start_value, input logic [7:0] limit_value);
    drain();
    write_config(CfgStartByte, start_value);
    write_config(CfgPayloadLimit, limit_value);
    settings_used++;
  endtask

  // Mostly well-formed frames with random content; the rest is stray bytes, read
  // requests, frames with a bad CRC and frames cut off part way. Lengths stay small
  // except for an occasional long one.
  task automatic run_random(input int unsigned target);
    int unsigned base;
    int pick;
    int len;
    int cut;
    bit corrupt;
    base = requests_sent - ignored_sent;
    while (requests_sent - ignored_sent - base < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        payload_q.delete();
        len = ($urandom_range(0, 33) == 0) ? $urandom_range(100, 255) : $urandom_range(0, 12);
        repeat (len) payload_q.push_back(8'($urandom));
        corrupt = ($urandom_range(0, 5) == 0);
        cut = ($urandom_range(0, 11) == 0) ? $urandom_range(1, len + 3) : -1;
        send_packet(8'($urandom), corrupt, cut);
      end else if (pick < 82) begin
        ignored_sent++;
        send_byte(8'($urandom));
      end else begin
        send_read(pick_read_index());
      end
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    out_stall_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CfgStartByte;
    cfg_data_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset settings. The first read is past the end of the
    // store, the only read allowed before any payload byte has been written.
    send_read(StoreDepth);
    // Stray bytes while waiting for a start byte are ignored.
    send_byte(8'h00);
    send_byte(8'hFF);
    // A frame with no payload goes straight to its CRC; it is good but not kept.
    payload_q.delete();
    send_packet(8'hFF, 1'b0, -1);
    // A short good frame with extreme payload values.
    payload_q = '{8'h00, 8'hFF, 8'hA5};
    send_packet(8'h00, 1'b0, -1);
    send_read(0);
    send_read(2);
    // A frame with a bad CRC still leaves its payload in the store.
    payload_q = '{8'h5A};
    send_packet(8'h81, 1'b1, -1);
    send_read(0);

    // Extreme settings: the highest start byte and a limit of zero, so nothing is kept.
    // A full-size frame fills the store so that its last entry can be read.
    configure(8'hFF, 8'h00);
    mix_reads = 1'b1;
    payload_q.delete();
    repeat (StoreDepth) payload_q.push_back(8'($urandom));
    send_packet(8'($urandom), 1'b0, -1);
    send_read(StoreDepth - 1);
    run_random(140);

    // Start byte zero and a small limit, with neither side idling.
    configure(8'h00, 8'd5);
    calm = 1'b1;
    run_random(160);
    calm = 1'b0;

    // Arbitrary start byte and a limit inside the usual range of lengths.
    configure(8'($urandom), 8'($urandom_range(1, 12)));
    run_random(160);

    // Back to the reset values, written explicitly.
    configure(StartByteReset, PayloadLimitReset);
    run_random(160);

    drain();
    $display("sent %0d requests over %0d register settings", requests_sent, settings_used);
    $display("%0d good frames (%0d kept), %0d crc errors, %0d read replies, %0d mismatches",
             sb.good_frames, sb.kept_frames, sb.crc_errors, sb.read_replies, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
